>>> hdl/ypcb_pkg.sv
// Shared constants and types for the yaw/pitch camera basis pipeline.
// Used by ypcb_cordic, yaw_pitch_to_camera_basis and the testbench; depends on nothing else.

package ypcb_pkg;

   // Input angle width: 2^ANGLE_BITS units per full turn.
   localparam int ANGLE_BITS    = 16;
   // Output fraction bits; results are Q1.OUT_FRAC_BITS, one sign bit in front.
   localparam int OUT_FRAC_BITS = 15;
   localparam int OUT_W         = OUT_FRAC_BITS + 1;

   // Rotation CORDIC working in Q.30 with a 32-bit turn for the angle.
   localparam int CORDIC_STEPS = 30;
   localparam int TURN_BITS    = 32;
   localparam int Q_FRAC       = 30;
   localparam int XY_W         = 33;
   localparam int Z_W          = 32;

   // Quadrant-mapped sine and cosine, and exact Q.60 products of two of them.
   localparam int TRIG_W    = 32;
   localparam int PROD_W    = 2 * TRIG_W;
   localparam int PROD_FRAC = 2 * Q_FRAC;

   // Pipeline depth of ypcb_cordic: input stage, one stage per step, quadrant map.
   localparam int CORDIC_LAT = CORDIC_STEPS + 2;

   localparam logic signed [XY_W-1:0] Q30_ONE         = XY_W'(64'h4000_0000);
   localparam logic signed [XY_W-1:0] CORDIC_GAIN_Q30 = XY_W'(64'h26DD_3B6A);

   // Sine and cosine of one angle in Q.30.
   typedef struct packed {
      logic signed [TRIG_W-1:0] cos_val;
      logic signed [TRIG_W-1:0] sin_val;
   } trig_type;

endpackage

>>> hdl/ypcb_cordic.sv
// Fully pipelined sine/cosine unit: one rotation CORDIC step per register stage.
// Depends on ypcb_pkg; instantiated twice by yaw_pitch_to_camera_basis.

module ypcb_cordic (
   input  logic                             clock,
   input  logic [ypcb_pkg::ANGLE_BITS-1:0]  angle_in,
   output ypcb_pkg::trig_type               trig_out
);
   import ypcb_pkg::*;

   typedef enum logic [1:0] {
      QUAD_0 = 2'd0,
      QUAD_1 = 2'd1,
      QUAD_2 = 2'd2,
      QUAD_3 = 2'd3
   } quad_type;

   // Arctangent of 2^-i in units of 2^-32 turn.
   localparam logic signed [Z_W-1:0] ATAN_TABLE [CORDIC_STEPS] = '{
      32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4, 32'sh028B0D43,
      32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55, 32'sh0028BE53, 32'sh00145F2F,
      32'sh000A2F98, 32'sh000517CC, 32'sh00028BE6, 32'sh000145F3, 32'sh0000A2FA,
      32'sh0000517D, 32'sh000028BE, 32'sh0000145F, 32'sh00000A30, 32'sh00000518,
      32'sh0000028C, 32'sh00000146, 32'sh000000A3, 32'sh00000051, 32'sh00000029,
      32'sh00000014, 32'sh0000000A, 32'sh00000005, 32'sh00000003, 32'sh00000001
   };

   logic signed [XY_W-1:0] x_in    [CORDIC_STEPS+1];
   logic signed [XY_W-1:0] y_in    [CORDIC_STEPS+1];
   logic signed [Z_W-1:0]  z_in    [CORDIC_STEPS+1];
   quad_type               quad_in [CORDIC_STEPS+1];
   logic                   zero_in [CORDIC_STEPS+1];

   logic signed [XY_W-1:0] x_ff    [CORDIC_STEPS+1];
   logic signed [XY_W-1:0] y_ff    [CORDIC_STEPS+1];
   logic signed [Z_W-1:0]  z_ff    [CORDIC_STEPS+1];
   quad_type               quad_ff [CORDIC_STEPS+1];
   logic                   zero_ff [CORDIC_STEPS+1];

   logic [TURN_BITS-1:0]   theta;
   logic signed [XY_W-1:0] x_final;
   logic signed [XY_W-1:0] y_final;
   trig_type               trig_in;
   trig_type               trig_ff;

   // Scale the angle to a 32-bit turn, split off the quadrant and the residual.
   always_comb begin
      theta      = {angle_in, {(TURN_BITS-ANGLE_BITS){1'b0}}};
      quad_in[0] = quad_type'(theta[TURN_BITS-1 -: 2]);
      z_in[0]    = Z_W'(theta[TURN_BITS-3:0]);
      zero_in[0] = (theta[TURN_BITS-3:0] == '0);
      x_in[0]    = CORDIC_GAIN_Q30;
      y_in[0]    = '0;
   end

   // One rotation per stage, toward a residual of zero; z >= 0 rotates forward.
   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
      always_comb begin
         if (!z_ff[k][Z_W-1]) begin
            x_in[k+1] = x_ff[k] - (y_ff[k] >>> k);
            y_in[k+1] = y_ff[k] + (x_ff[k] >>> k);
            z_in[k+1] = z_ff[k] - ATAN_TABLE[k];
         end else begin
            x_in[k+1] = x_ff[k] + (y_ff[k] >>> k);
            y_in[k+1] = y_ff[k] - (x_ff[k] >>> k);
            z_in[k+1] = z_ff[k] + ATAN_TABLE[k];
         end
         quad_in[k+1] = quad_ff[k];
         zero_in[k+1] = zero_ff[k];
      end
   end

   // An exact quadrant boundary bypasses the rotations; then map by quadrant.
   always_comb begin
      x_final = zero_ff[CORDIC_STEPS] ? Q30_ONE : x_ff[CORDIC_STEPS];
      y_final = zero_ff[CORDIC_STEPS] ? '0 : y_ff[CORDIC_STEPS];
      unique case (quad_ff[CORDIC_STEPS])
         QUAD_0: begin
            trig_in.cos_val = TRIG_W'(x_final);
            trig_in.sin_val = TRIG_W'(y_final);
         end
         QUAD_1: begin
            trig_in.cos_val = TRIG_W'(-y_final);
            trig_in.sin_val = TRIG_W'(x_final);
         end
         QUAD_2: begin
            trig_in.cos_val = TRIG_W'(-x_final);
            trig_in.sin_val = TRIG_W'(-y_final);
         end
         QUAD_3: begin
            trig_in.cos_val = TRIG_W'(y_final);
            trig_in.sin_val = TRIG_W'(-x_final);
         end
         default: begin
            trig_in.cos_val = TRIG_W'(x_final);
            trig_in.sin_val = TRIG_W'(y_final);
         end
      endcase
   end

   // Stage registers; data only, so no reset.
   always_ff @(posedge clock) begin
      for (int i = 0; i <= CORDIC_STEPS; i++) begin
         x_ff[i]    <= x_in[i];
         y_ff[i]    <= y_in[i];
         z_ff[i]    <= z_in[i];
         quad_ff[i] <= quad_in[i];
         zero_ff[i] <= zero_in[i];
      end
      trig_ff <= trig_in;
   end

   assign trig_out = trig_ff;

endmodule

>>> hdl/yaw_pitch_to_camera_basis.sv
// Top level: forward, right and up camera vectors from a pitch and a yaw angle.
// Depends on ypcb_pkg and ypcb_cordic (one instance per angle).
//
//  channel   ports                              handshake
//  -------   --------------------------------   ------------------------------
//  request   req_pitch_angle, req_yaw_angle     taken when start high, busy low
//  response  rsp_forward_*, rsp_right_x/z,      rsp_valid high for one cycle,
//            rsp_up_*                           no back-pressure
//
// A transaction enters every cycle while busy is low; its response passes through
// the 32 stages of the pipelined CORDIC, then sign selection, the 32x32
// multipliers and rounding with saturation, one stage each.
// Synchronous reset clears the valid line and holds busy high during reset and in the cycle after it.
// At all other times busy stays low: nothing downstream can stall the pipeline.

module yaw_pitch_to_camera_basis (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic        [ypcb_pkg::ANGLE_BITS-1:0]  req_pitch_angle,
   input  logic        [ypcb_pkg::ANGLE_BITS-1:0]  req_yaw_angle,
   output logic                                    rsp_valid,
   output logic signed [ypcb_pkg::OUT_W-1:0]       rsp_forward_x,
   output logic signed [ypcb_pkg::OUT_W-1:0]       rsp_forward_y,
   output logic signed [ypcb_pkg::OUT_W-1:0]       rsp_forward_z,
   output logic signed [ypcb_pkg::OUT_W-1:0]       rsp_right_x,
   output logic signed [ypcb_pkg::OUT_W-1:0]       rsp_right_z,
   output logic signed [ypcb_pkg::OUT_W-1:0]       rsp_up_x,
   output logic signed [ypcb_pkg::OUT_W-1:0]       rsp_up_y,
   output logic signed [ypcb_pkg::OUT_W-1:0]       rsp_up_z
);
   import ypcb_pkg::*;

   localparam int TOTAL_LAT = CORDIC_LAT + 3;
   localparam int RND_SHIFT = PROD_FRAC - OUT_FRAC_BITS;

   localparam logic signed [PROD_W:0] RND_HALF = (PROD_W+1)'(1) <<< (RND_SHIFT - 1);
   localparam logic signed [PROD_W:0] SAT_HI   = ((PROD_W+1)'(1) <<< OUT_FRAC_BITS) - 1;
   localparam logic signed [PROD_W:0] SAT_LO   = ~SAT_HI;

   // Operands after the sign of the pitch cosine has been applied.
   typedef struct packed {
      logic signed [TRIG_W-1:0] cp;
      logic signed [TRIG_W-1:0] sp;
      logic signed [TRIG_W-1:0] cy;
      logic signed [TRIG_W-1:0] sy;
      logic signed [TRIG_W-1:0] neg_s_sy;
      logic signed [TRIG_W-1:0] s_cy;
      logic signed [TRIG_W-1:0] neg_s_cy;
      logic signed [TRIG_W-1:0] s_cp;
   } operand_type;

   // All eight components in Q.60 before rounding.
   typedef struct packed {
      logic signed [PROD_W-1:0] fwd_x;
      logic signed [PROD_W-1:0] fwd_y;
      logic signed [PROD_W-1:0] fwd_z;
      logic signed [PROD_W-1:0] rgt_x;
      logic signed [PROD_W-1:0] rgt_z;
      logic signed [PROD_W-1:0] up_x;
      logic signed [PROD_W-1:0] up_y;
      logic signed [PROD_W-1:0] up_z;
   } basis_type;

   // Move a Q.30 value to Q.60 so every component takes the same rounding.
   function automatic logic signed [PROD_W-1:0] align_q30(
      input logic signed [TRIG_W-1:0] v
   );
      logic signed [PROD_W-1:0] ext;
      ext = PROD_W'(v);
      return ext <<< Q_FRAC;
   endfunction

   // Round half toward plus infinity, then clamp to the output range.
   function automatic logic signed [OUT_W-1:0] round_sat(
      input logic signed [PROD_W-1:0] v
   );
      logic signed [PROD_W:0] sum;
      logic signed [PROD_W:0] shifted;
      sum     = (PROD_W+1)'(v) + RND_HALF;
      shifted = sum >>> RND_SHIFT;
      if (shifted > SAT_HI) begin
         return OUT_W'(SAT_HI);
      end else if (shifted < SAT_LO) begin
         return OUT_W'(SAT_LO);
      end
      return OUT_W'(shifted);
   endfunction

   logic                  accept;
   logic                  busy_ff;
   logic [TOTAL_LAT-1:0]  valid_in;
   logic [TOTAL_LAT-1:0]  valid_ff;

   trig_type              pitch_trig;
   trig_type              yaw_trig;
   logic                  cp_pos;
   operand_type           opnd_in;
   operand_type           opnd_ff;
   basis_type             prod_in;
   basis_type             prod_ff;

   logic signed [OUT_W-1:0] fwd_x_ff, fwd_y_ff, fwd_z_ff;
   logic signed [OUT_W-1:0] rgt_x_ff, rgt_z_ff;
   logic signed [OUT_W-1:0] up_x_ff, up_y_ff, up_z_ff;

   assign accept = start && !busy_ff;

   // Sine and cosine of both angles, one pipelined unit each.
   ypcb_cordic u_pitch_cordic (
      .clock    (clock),
      .angle_in (req_pitch_angle),
      .trig_out (pitch_trig)
   );

   ypcb_cordic u_yaw_cordic (
      .clock    (clock),
      .angle_in (req_yaw_angle),
      .trig_out (yaw_trig)
   );

   // Apply the sign of the pitch cosine; zero counts as positive.
   always_comb begin
      cp_pos           = !pitch_trig.cos_val[TRIG_W-1];
      opnd_in.cp       = pitch_trig.cos_val;
      opnd_in.sp       = pitch_trig.sin_val;
      opnd_in.cy       = yaw_trig.cos_val;
      opnd_in.sy       = yaw_trig.sin_val;
      opnd_in.neg_s_sy = cp_pos ? -yaw_trig.sin_val : yaw_trig.sin_val;
      opnd_in.s_cy     = cp_pos ? yaw_trig.cos_val : -yaw_trig.cos_val;
      opnd_in.neg_s_cy = cp_pos ? -yaw_trig.cos_val : yaw_trig.cos_val;
      opnd_in.s_cp     = cp_pos ? pitch_trig.cos_val : -pitch_trig.cos_val;
   end

   // Products kept exact in Q.60; single-factor components are aligned to match.
   always_comb begin
      prod_in.fwd_x = PROD_W'(opnd_ff.cy) * PROD_W'(opnd_ff.cp);
      prod_in.fwd_y = align_q30(opnd_ff.sp);
      prod_in.fwd_z = PROD_W'(opnd_ff.sy) * PROD_W'(opnd_ff.cp);
      prod_in.rgt_x = align_q30(opnd_ff.neg_s_sy);
      prod_in.rgt_z = align_q30(opnd_ff.s_cy);
      prod_in.up_x  = PROD_W'(opnd_ff.neg_s_cy) * PROD_W'(opnd_ff.sp);
      prod_in.up_y  = align_q30(opnd_ff.s_cp);
      prod_in.up_z  = PROD_W'(opnd_ff.neg_s_sy) * PROD_W'(opnd_ff.sp);
   end

   // Valid bits run alongside the data through every stage.
   assign valid_in = {valid_ff[TOTAL_LAT-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b1;
         valid_ff <= '0;
      end else begin
         busy_ff  <= 1'b0;
         valid_ff <= valid_in;
      end
   end

   // Datapath registers after the CORDIC units.
   always_ff @(posedge clock) begin
      opnd_ff  <= opnd_in;
      prod_ff  <= prod_in;
      fwd_x_ff <= round_sat(prod_ff.fwd_x);
      fwd_y_ff <= round_sat(prod_ff.fwd_y);
      fwd_z_ff <= round_sat(prod_ff.fwd_z);
      rgt_x_ff <= round_sat(prod_ff.rgt_x);
      rgt_z_ff <= round_sat(prod_ff.rgt_z);
      up_x_ff  <= round_sat(prod_ff.up_x);
      up_y_ff  <= round_sat(prod_ff.up_y);
      up_z_ff  <= round_sat(prod_ff.up_z);
   end

   assign busy          = busy_ff;
   assign rsp_valid     = valid_ff[TOTAL_LAT-1];
   assign rsp_forward_x = fwd_x_ff;
   assign rsp_forward_y = fwd_y_ff;
   assign rsp_forward_z = fwd_z_ff;
   assign rsp_right_x   = rgt_x_ff;
   assign rsp_right_z   = rgt_z_ff;
   assign rsp_up_x      = up_x_ff;
   assign rsp_up_y      = up_y_ff;
   assign rsp_up_z      = up_z_ff;

   // Every accepted transaction produces its response after the full latency.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##TOTAL_LAT rsp_valid)
      else $error("response missing after accepted transaction");

   // The up vector never points below the horizon.
   a_up_y_nonneg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_up_y[OUT_W-1])
      else $error("up_y negative");

   // Zero pitch takes the exact boundary path, so forward_y is exactly zero.
   a_pitch_zero: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_pitch_angle == '0 |-> ##TOTAL_LAT rsp_forward_y == '0)
      else $error("forward_y not zero at zero pitch");

   // Zero yaw gives a right vector with no x component.
   a_yaw_zero: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_yaw_angle == '0 |-> ##TOTAL_LAT rsp_right_x == '0)
      else $error("right_x not zero at zero yaw");

endmodule

>>> tb/yaw_pitch_to_camera_basis_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for yaw_pitch_to_camera_basis: directed and random angle pairs.
// Depends on ypcb_pkg for widths; holds its own CORDIC-based predictor and scoreboard.

package ypcb_tb_pkg;
   import ypcb_pkg::*;

   // Arctangent of 2^-i in units of 2^-32 turn, one entry per rotation step.
   localparam longint ATAN_TURN [CORDIC_STEPS] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
      64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
      64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
      64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
      64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001
   };

   typedef logic signed [OUT_W-1:0] q_out_t;
   typedef logic [ANGLE_BITS-1:0]   angle_t;

   typedef struct packed {
      q_out_t forward_x;
      q_out_t forward_y;
      q_out_t forward_z;
      q_out_t right_x;
      q_out_t right_z;
      q_out_t up_x;
      q_out_t up_y;
      q_out_t up_z;
   } basis_t;

   // Cosine and sine of a binary angle in Q.30: quadrant select plus a rotation CORDIC
   // on the residual, with exact values on the quadrant boundaries.
   function automatic void angle_trig(input angle_t angle, output longint cos_q30,
                                      output longint sin_q30);
      logic [TURN_BITS-1:0] theta;
      logic [1:0]           quad;
      longint               x, y, z, dx, dy;
      theta = {angle, {(TURN_BITS - ANGLE_BITS){1'b0}}};
      quad  = theta[TURN_BITS-1 -: 2];
      z     = longint'({34'd0, theta[TURN_BITS-3:0]});
      if (z == 0) begin
         x = longint'(1) << Q_FRAC;
         y = 0;
      end else begin
         x = 64'h26DD3B6A;
         y = 0;
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x = x - dx;
               y = y + dy;
               z = z - ATAN_TURN[i];
            end else begin
               x = x + dx;
               y = y - dy;
               z = z + ATAN_TURN[i];
            end
         end
      end
      case (quad)
         2'd0: begin cos_q30 = x;  sin_q30 = y;  end
         2'd1: begin cos_q30 = -y; sin_q30 = x;  end
         2'd2: begin cos_q30 = -x; sin_q30 = -y; end
         default: begin cos_q30 = y; sin_q30 = -x; end
      endcase
   endfunction

   // Round half up to OUT_FRAC_BITS fraction bits, then clamp to the Q1 range.
   function automatic q_out_t round_to_q(input longint v, input int frac);
      int     sh;
      longint hi, lo;
      sh = frac - OUT_FRAC_BITS;
      hi = (longint'(1) << OUT_FRAC_BITS) - 1;
      lo = -(longint'(1) << OUT_FRAC_BITS);
      v  = (v + (longint'(1) << (sh - 1))) >>> sh;
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return q_out_t'(v);
   endfunction

   // Camera basis for one pitch/yaw pair. The pitch cosine sign is taken as
   // positive when that cosine is exactly zero.
   function automatic basis_t camera_basis(input angle_t pitch, input angle_t yaw);
      longint cp, sp, cy, sy, sg;
      basis_t b;
      angle_trig(pitch, cp, sp);
      angle_trig(yaw, cy, sy);
      sg = (cp >= 0) ? 1 : -1;
      b.forward_x = round_to_q(cy * cp, PROD_FRAC);
      b.forward_y = round_to_q(sp, Q_FRAC);
      b.forward_z = round_to_q(sy * cp, PROD_FRAC);
      b.right_x   = round_to_q(-sg * sy, Q_FRAC);
      b.right_z   = round_to_q(sg * cy, Q_FRAC);
      b.up_x      = round_to_q(-sg * (cy * sp), PROD_FRAC);
      b.up_y      = round_to_q(sg * cp, Q_FRAC);
      b.up_z      = round_to_q(-sg * (sy * sp), PROD_FRAC);
      return b;
   endfunction

   // Holds the bases still owed by the block, oldest first, and checks each response.
   class camera_basis_tracker;
      basis_t expected_bases[$];
      int     mismatches = 0;

      function void note_angles(angle_t pitch, angle_t yaw);
         expected_bases.push_back(camera_basis(pitch, yaw));
      endfunction

      function void compare_field(string name, q_out_t want, q_out_t got);
         if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_basis(basis_t got);
         basis_t want;
         if (expected_bases.size() == 0) begin
            $error("response transaction with no request outstanding");
            mismatches++;
            return;
         end
         want = expected_bases.pop_front();
         compare_field("forward_x", want.forward_x, got.forward_x);
         compare_field("forward_y", want.forward_y, got.forward_y);
         compare_field("forward_z", want.forward_z, got.forward_z);
         compare_field("right_x", want.right_x, got.right_x);
         compare_field("right_z", want.right_z, got.right_z);
         compare_field("up_x", want.up_x, got.up_x);
         compare_field("up_y", want.up_y, got.up_y);
         compare_field("up_z", want.up_z, got.up_z);
      endfunction

      function int outstanding();
         return expected_bases.size();
      endfunction
   endclass

endpackage

module yaw_pitch_to_camera_basis_tb;
   import ypcb_pkg::*;
   import ypcb_tb_pkg::*;

   localparam int RANDOM_ITEMS   = 1800;
   localparam int STEADY_ITEMS   = 300;
   localparam int PHASE_ITEMS    = 150;
   localparam int DIRECTED_ITEMS = 20;
   localparam int DRAIN_CYCLES   = CORDIC_LAT + 3 + 16;
   localparam int CYCLE_LIMIT    = 300000;

   logic   clock;
   logic   reset;
   logic   start;
   logic   busy;
   angle_t req_pitch_angle;
   angle_t req_yaw_angle;
   logic   rsp_valid;
   q_out_t rsp_forward_x, rsp_forward_y, rsp_forward_z;
   q_out_t rsp_right_x, rsp_right_z;
   q_out_t rsp_up_x, rsp_up_y, rsp_up_z;

   int unsigned         cycle_count = 0;
   camera_basis_tracker tracker = new();

   // Quadrant boundaries, their neighbors, the ends of the angle range and some angles inside a quadrant.
   angle_t directed_pitch [DIRECTED_ITEMS] = '{
      16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000,
      16'h0001, 16'h3FFF, 16'h4001, 16'hC001, 16'h7FFF, 16'h8001, 16'hBFFF, 16'h2000,
      16'hA000, 16'h4000, 16'hC000, 16'h8000
   };
   angle_t directed_yaw [DIRECTED_ITEMS] = '{
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'h4000, 16'h8000, 16'hC000,
      16'h0001, 16'h7FFF, 16'hBFFF, 16'h4001, 16'hC000, 16'h2000, 16'hE000, 16'h6000,
      16'h1234, 16'h4000, 16'hC000, 16'h8000
   };

   yaw_pitch_to_camera_basis uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_pitch_angle (req_pitch_angle),
      .req_yaw_angle   (req_yaw_angle),
      .rsp_valid       (rsp_valid),
      .rsp_forward_x   (rsp_forward_x),
      .rsp_forward_y   (rsp_forward_y),
      .rsp_forward_z   (rsp_forward_z),
      .rsp_right_x     (rsp_right_x),
      .rsp_right_z     (rsp_right_z),
      .rsp_up_x        (rsp_up_x),
      .rsp_up_y        (rsp_up_y),
      .rsp_up_z        (rsp_up_z)
   );

   // 10 ns clock.
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Sample both channels on the edge that accepts them.
   always @(posedge clock) begin : channel_monitor
      basis_t got;
      if (!reset) begin
         if (start && !busy)
            tracker.note_angles(req_pitch_angle, req_yaw_angle);
         if (rsp_valid) begin
            got.forward_x = rsp_forward_x;
            got.forward_y = rsp_forward_y;
            got.forward_z = rsp_forward_z;
            got.right_x   = rsp_right_x;
            got.right_z   = rsp_right_z;
            got.up_x      = rsp_up_x;
            got.up_y      = rsp_up_y;
            got.up_z      = rsp_up_z;
            tracker.check_basis(got);
         end
      end
   end

   // Present one angle pair and hold it until the block takes the transaction.
   task automatic send_angles(input angle_t pitch, input angle_t yaw);
      start           <= 1'b1;
      req_pitch_angle <= pitch;
      req_yaw_angle   <= yaw;
      do @(posedge clock); while (busy);
   endtask

   // Drop start, with junk on the request fields, for as many cycles as the argument gives.
   task automatic hold_off(input int cycles);
      start           <= 1'b0;
      req_pitch_angle <= angle_t'($urandom);
      req_yaw_angle   <= angle_t'($urandom);
      repeat (cycles) @(posedge clock);
   endtask

   // Mostly uniform angles, with a good share close to or on a quadrant boundary.
   function automatic angle_t pick_angle();
      angle_t corner;
      corner = angle_t'($urandom_range(0, 3)) << (ANGLE_BITS - 2);
      case ($urandom_range(0, 9))
         6, 7:    return corner + angle_t'($urandom_range(0, 6)) - angle_t'(3);
         8:       return corner;
         9:       return $urandom_range(0, 1) ? '1 : '0;
         default: return angle_t'($urandom);
      endcase
   endfunction

   initial begin : stimulus
      bit idle_phase;
      start           <= 1'b0;
      reset           <= 1'b1;
      req_pitch_angle <= '0;
      req_yaw_angle   <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed corners, back to back.
      for (int i = 0; i < DIRECTED_ITEMS; i++)
         send_angles(directed_pitch[i], directed_yaw[i]);

      // Random pairs; idling switches on and off by phase and stops near the end.
      idle_phase = 1'b1;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % PHASE_ITEMS == 0)
            idle_phase = $urandom_range(0, 2) != 0;
         if (idle_phase && i < RANDOM_ITEMS - STEADY_ITEMS && $urandom_range(0, 2) == 0)
            hold_off($urandom_range(1, 13));
         send_angles(pick_angle(), pick_angle());
      end
      start <= 1'b0;

      // Let the pipeline drain, then watch a little longer for stray responses.
      while (tracker.outstanding() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (tracker.mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
